// File: sv/hil_pkg.sv
// ----------------------------------------------------------------------------
// hil_pkg
// Shared constants, command/status types and the home slot hash for the
// linear probing insert core.
// ----------------------------------------------------------------------------
package hil_pkg;

	localparam int TABLE_SLOTS    = 128;
	localparam int KEY_BYTES      = 4;
	localparam int WORDS_PER_SLOT = 5;
	localparam int REC_DEPTH      = TABLE_SLOTS * WORDS_PER_SLOT;

	localparam int SLOT_W  = $clog2(TABLE_SLOTS);
	localparam int PROBE_W = $clog2(TABLE_SLOTS + 1);
	localparam int REC_AW  = $clog2(REC_DEPTH);
	localparam int WORD_W  = $clog2(WORDS_PER_SLOT);
	localparam int SUM_W   = $clog2(KEY_BYTES * 255 + 1);
	localparam int FILL_W  = 8;

	localparam int IN_W  = 296;
	localparam int OUT_W = 24;

	localparam logic [1:0] ST_HOME   = 2'd0;
	localparam logic [1:0] ST_PROBED = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic load;
		logic step;
		logic claim;
		logic wr_rec;
		logic load_out;
	} hil_cmd_t;

	typedef struct packed {
		logic full;
		logic hit;
		logic word_last;
	} hil_stat_t;

	// sum of key bytes up to the first zero byte, modulo table size
	function automatic logic [SLOT_W-1:0] home_of(input logic [31:0] key);
		logic [SUM_W-1:0] sum;
		logic             stop;
		logic [7:0]       b;
		sum  = '0;
		stop = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			b = key[8*i +: 8];
			if (b == 8'd0) begin
				stop = 1'b1;
			end
			if (!stop) begin
				sum = sum + SUM_W'(b);
			end
		end
		return sum[SLOT_W-1:0];
	endfunction

endpackage

// File: sv/hash_insert_linear_probing_core.sv
// sequence: an accepted word loads the key and record, the probe steps past occupied
// slots from the home slot, the first free slot is claimed and its five record words
// are written, then the result is handed off; a full table ends after all 128 slots.
// flow: one insert at a time; a new word is taken only after the result is handed off,
// and a waiting result word holds the hand-off for m_tready.
// reset: arst_n clears every occupancy bit and the fill count at once.
// ----------------------------------------------------------------------------
// hash_insert_linear_probing_core
// Linear probing hash table insert: hashes the key to a home slot, probes for
// the first free slot and stores the key and record there.
// ----------------------------------------------------------------------------
module hash_insert_linear_probing_core
	import hil_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// key_bytes, name_part_a, name_part_b, name_part_c, dept_part_a, dept_part_b
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// status, slot_index, probe_count, zero fill
	output logic [OUT_W-1:0] m_tdata
);

	hil_cmd_t  cmd;
	hil_stat_t stat;

	hil_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hil_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.stat    (stat)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("word accepted while insert in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == ST_HOME || m_tdata[1:0] == ST_PROBED ||
			m_tdata[1:0] == ST_FULL))
		else $error("undefined status code");

	a_home_no_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == ST_HOME) |-> (m_tdata[16:9] == 8'd0))
		else $error("home slot result with nonzero probe count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == ST_FULL) |-> (m_tdata[16:9] == 8'(TABLE_SLOTS)))
		else $error("full result without a complete probe sweep");

endmodule

// File: sv/hil_ctrl.sv
// ----------------------------------------------------------------------------
// hil_ctrl
// Insert sequencer: accepts a word, steps the probe, writes the record words
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module hil_ctrl
	import hil_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  hil_stat_t stat,
	output hil_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_PROBE  = 4'b0010,
		S_WRITE  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_PROBE;
				end
			end
			S_PROBE: begin
				if (stat.full) begin
					state_d = S_FINISH;
				end else if (stat.hit) begin
					cmd.step = 1'b1;
				end else begin
					cmd.claim = 1'b1;
					state_d   = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.wr_rec = 1'b1;
				if (stat.word_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// File: sv/hil_dpath.sv
// ----------------------------------------------------------------------------
// hil_dpath
// Probe index and counter, occupancy bits, key and record stores, fill count
// and the result register.
// ----------------------------------------------------------------------------
module hil_dpath
	import hil_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  s_tdata,
	output logic [OUT_W-1:0] m_tdata,
	input  hil_cmd_t         cmd,
	output hil_stat_t        stat
);

	logic [TABLE_SLOTS-1:0] slot_used_q;
	logic [SLOT_W-1:0]      idx_q;
	logic [PROBE_W-1:0]     probes_q;
	logic [WORD_W-1:0]      word_q;
	logic [FILL_W-1:0]      fill_q;

	logic [31:0] key_q;
	logic [63:0] name_a_q;
	logic [63:0] name_b_q;
	logic [23:0] name_c_q;
	logic [63:0] dept_a_q;
	logic [47:0] dept_b_q;

	logic [1:0]         res_status_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic [PROBE_W-1:0] res_probes_q;

	logic [31:0] key_mem [TABLE_SLOTS];
	logic [63:0] rec_mem [REC_DEPTH];

	logic [REC_AW-1:0] rec_addr;
	logic [63:0]       rec_word;

	assign stat.full      = (probes_q == PROBE_W'(TABLE_SLOTS));
	assign stat.hit       = slot_used_q[idx_q];
	assign stat.word_last = (word_q == WORD_W'(WORDS_PER_SLOT - 1));

	// slot * 5 + word
	assign rec_addr = REC_AW'({idx_q, 2'b00}) + REC_AW'(idx_q) + REC_AW'(word_q);

	always_comb begin
		case (word_q)
			3'd0:    rec_word = name_a_q;
			3'd1:    rec_word = name_b_q;
			3'd2:    rec_word = {40'd0, name_c_q};
			3'd3:    rec_word = dept_a_q;
			default: rec_word = {16'd0, dept_b_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_used_q <= '0;
			idx_q       <= '0;
			probes_q    <= '0;
			word_q      <= '0;
			fill_q      <= '0;
		end else begin
			if (cmd.load) begin
				idx_q    <= home_of(s_tdata[31:0]);
				probes_q <= '0;
			end else if (cmd.step) begin
				idx_q    <= idx_q + 1'b1;
				probes_q <= probes_q + 1'b1;
			end
			if (cmd.claim) begin
				slot_used_q[idx_q] <= 1'b1;
				word_q             <= '0;
				if (fill_q != '1) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (cmd.wr_rec) begin
				word_q <= word_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= s_tdata[31:0];
			name_a_q <= s_tdata[95:32];
			name_b_q <= s_tdata[159:96];
			name_c_q <= s_tdata[183:160];
			dept_a_q <= s_tdata[247:184];
			dept_b_q <= s_tdata[295:248];
		end
		if (cmd.claim) begin
			key_mem[idx_q] <= key_q;
		end
		if (cmd.wr_rec) begin
			rec_mem[rec_addr] <= rec_word;
		end
		if (cmd.load_out) begin
			res_slot_q   <= idx_q;
			res_probes_q <= probes_q;
			if (stat.full) begin
				res_status_q <= ST_FULL;
			end else if (probes_q == '0) begin
				res_status_q <= ST_HOME;
			end else begin
				res_status_q <= ST_PROBED;
			end
		end
	end

	assign m_tdata = {7'd0, res_probes_q, res_slot_q, res_status_q};

endmodule
